/* rtl/marked_sequence_loader_core_macros.svh */
// ----------------------------------------------------------------------------
// Marked sequence loader assertion macros
// Shared clocked property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef MARKED_SEQUENCE_LOADER_CORE_MACROS_SVH
`define MARKED_SEQUENCE_LOADER_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define MSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define MSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/msl_pkg.sv */
// ----------------------------------------------------------------------------
// msl_pkg
// Types, codes and sizes shared by the marked sequence loader.
// ----------------------------------------------------------------------------
`default_nettype none

package msl_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W       = 6;
  localparam int CMP_W       = COUNT_W + IDX_W;

  // commands
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_POSE    = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_BAD_IDX = 2'd3;

  // reported sequence state
  localparam logic [1:0] SEQ_IDLE    = 2'd0;
  localparam logic [1:0] SEQ_LOADING = 2'd1;
  localparam logic [1:0] SEQ_READY   = 2'd2;
  localparam logic [1:0] SEQ_ERROR   = 2'd3;

  // events
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_BEGAN    = 3'd1;
  localparam logic [2:0] EV_FINISHED = 3'd2;
  localparam logic [2:0] EV_APPENDED = 3'd3;
  localparam logic [2:0] EV_OVERFLOW = 3'd4;
  localparam logic [2:0] EV_TIMEOUT  = 3'd5;
  localparam logic [2:0] EV_IGNORED  = 3'd6;

  // marker patterns
  localparam logic [31:0] BITS_FIVE  = 32'h40A0_0000;
  localparam logic [31:0] BITS_EIGHT = 32'h4100_0000;
  localparam logic [15:0] ROLL_BEGIN = 16'd5;
  localparam logic [15:0] ROLL_END   = 16'd8;
  localparam logic [7:0]  ACT_BEGIN  = 8'd5;
  localparam logic [7:0]  ACT_END    = 8'd8;

  localparam logic [15:0] TIMEOUT_RESET = 16'd30000;

  typedef enum logic [3:0] {
    LS_IDLE    = 4'b0001,
    LS_LOADING = 4'b0010,
    LS_READY   = 4'b0100,
    LS_ERROR   = 4'b1000
  } load_state_t;

  typedef struct packed {
    logic [31:0]        x;
    logic [31:0]        y;
    logic [31:0]        z;
    logic signed [15:0] roll;
    logic [7:0]         action;
  } pose_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        pos_z;
    logic signed [15:0] roll_tenths;
    logic [7:0]         action_code;
    logic [IDX_W-1:0]   read_index;
  } req_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        out_x;
    logic [31:0]        out_y;
    logic [31:0]        out_z;
    logic signed [15:0] out_roll;
    logic [7:0]         out_action;
    logic [1:0]         seq_state;
    logic [COUNT_W-1:0] stored_count;
    logic               overflow_flag;
    logic [15:0]        generation;
    logic [2:0]         event_res;
  } rsp_t;

  // store access issued with an accepted item
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    pose_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  // step outcome, waiting on store read data when kind is KIND_READ
  typedef struct packed {
    logic [1:0]         kind;
    pose_t              shown;
    logic [1:0]         seq_state;
    logic [COUNT_W-1:0] stored_count;
    logic               overflow_flag;
    logic [15:0]        generation;
    logic [2:0]         event_res;
  } step_meta_t;

  function automatic logic [1:0] encode_state(input load_state_t s);
    logic [1:0] code;
    unique case (s)
      LS_IDLE:    code = SEQ_IDLE;
      LS_LOADING: code = SEQ_LOADING;
      LS_READY:   code = SEQ_READY;
      LS_ERROR:   code = SEQ_ERROR;
      default:    code = SEQ_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/msl_store.sv */
// ----------------------------------------------------------------------------
// msl_store
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msl_store
  import msl_pkg::*;
(
  input  wire        clk,
  input  store_req_t acc,
  output pose_t      rdata
);

  pose_t mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (acc.we) begin
      mem[acc.waddr] <= acc.wdata;
    end
    if (acc.re) begin
      rdata <= mem[acc.raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/msl_step.sv */
// ----------------------------------------------------------------------------
// msl_step
// Load control: marker decode, counters, timeout and store access per item.
// ----------------------------------------------------------------------------
`default_nettype none

module msl_step
  import msl_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         accept,
  input  req_t        req,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_data,
  output store_req_t  acc,
  output step_meta_t  meta
);

  load_state_t        state, state_next;
  logic [COUNT_W-1:0] count, count_next;
  logic               ovf, ovf_next;
  logic [15:0]        gen, gen_next;
  logic [15:0]        quiet, quiet_next, quiet_inc;
  logic [15:0]        timeout;

  pose_t      f;
  logic       is_begin;
  logic       is_end;
  logic       idx_ok;
  logic       store_full;
  logic [1:0] kind;
  logic [2:0] ev;
  pose_t      shown;

  assign f.x      = req.pos_x;
  assign f.y      = req.pos_y;
  assign f.z      = req.pos_z;
  assign f.roll   = req.roll_tenths;
  assign f.action = req.action_code;

  assign is_begin = (req.pos_x == BITS_FIVE) && (req.pos_y == BITS_FIVE) &&
                    (req.pos_z == BITS_FIVE) &&
                    ($unsigned(req.roll_tenths) == ROLL_BEGIN) &&
                    (req.action_code == ACT_BEGIN);
  assign is_end   = (req.pos_x == BITS_EIGHT) && (req.pos_y == BITS_EIGHT) &&
                    (req.pos_z == BITS_EIGHT) &&
                    ($unsigned(req.roll_tenths) == ROLL_END) &&
                    (req.action_code == ACT_END);

  assign idx_ok     = (CMP_W'(req.read_index) < CMP_W'(count)) &&
                      (CMP_W'(req.read_index) < CMP_W'(STORE_DEPTH));
  assign store_full = (CMP_W'(count) >= CMP_W'(STORE_DEPTH));
  assign quiet_inc  = (quiet == 16'hFFFF) ? quiet : quiet + 16'd1;

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    gen_next   = gen;
    quiet_next = quiet;
    kind       = KIND_NONE;
    ev         = EV_NONE;
    shown      = '0;
    acc.we     = 1'b0;
    acc.re     = 1'b0;
    acc.waddr  = count[ADDR_W-1:0];
    acc.wdata  = f;
    acc.raddr  = ADDR_W'(req.read_index);
    case (req.command)
      CMD_FRAME: begin
        if (is_begin) begin
          quiet_next = '0;
          count_next = '0;
          ovf_next   = 1'b0;
          state_next = LS_LOADING;
          gen_next   = gen + 16'd1;
          ev         = EV_BEGAN;
        end else if (is_end) begin
          quiet_next = '0;
          if (state == LS_LOADING) begin
            state_next = ((count != '0) && !ovf) ? LS_READY : LS_IDLE;
          end
          gen_next = gen + 16'd1;
          ev       = EV_FINISHED;
        end else begin
          unique case (state)
            LS_LOADING: begin
              if (store_full) begin
                ovf_next   = 1'b1;
                state_next = LS_ERROR;
                gen_next   = gen + 16'd1;
                ev         = EV_OVERFLOW;
              end else begin
                acc.we     = 1'b1;
                count_next = count + COUNT_W'(1);
                quiet_next = '0;
                ev         = EV_APPENDED;
              end
            end
            LS_IDLE, LS_ERROR: begin
              shown = f;
              kind  = KIND_POSE;
            end
            default: ev = EV_IGNORED;
          endcase
        end
      end
      CMD_TICK: begin
        quiet_next = quiet_inc;
        if ((state == LS_LOADING) && (quiet_inc >= timeout)) begin
          state_next = LS_ERROR;
          gen_next   = gen + 16'd1;
          ev         = EV_TIMEOUT;
        end
      end
      CMD_READ: begin
        if (idx_ok) begin
          acc.re = 1'b1;
          kind   = KIND_READ;
        end else begin
          kind = KIND_BAD_IDX;
        end
      end
      default: ev = EV_IGNORED;
    endcase
    acc.we = acc.we & accept;
    acc.re = acc.re & accept;
  end

  assign meta.kind          = kind;
  assign meta.shown         = shown;
  assign meta.seq_state     = encode_state(state_next);
  assign meta.stored_count  = count_next;
  assign meta.overflow_flag = ovf_next;
  assign meta.generation    = gen_next;
  assign meta.event_res     = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= LS_IDLE;
      count   <= '0;
      ovf     <= 1'b0;
      gen     <= '0;
      quiet   <= '0;
      timeout <= TIMEOUT_RESET;
    end else begin
      if (accept) begin
        state <= state_next;
        count <= count_next;
        ovf   <= ovf_next;
        gen   <= gen_next;
        quiet <= quiet_next;
      end
      if (cfg_we) begin
        timeout <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/msl_outq.sv */
// ----------------------------------------------------------------------------
// msl_outq
// Two result stages: one waits on store read data, one drives the port.
// ----------------------------------------------------------------------------
`default_nettype none

module msl_outq
  import msl_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        accept,
  input  step_meta_t meta,
  input  pose_t      rdata,
  output logic       busy,
  output logic       rsp_valid,
  input  wire        rsp_stall,
  output rsp_t       rsp
);

  logic       b_valid;
  step_meta_t b_meta;
  logic       b_adv;
  pose_t      pose;
  rsp_t       fmt;

  assign b_adv = !rsp_valid || !rsp_stall;
  assign busy  = b_valid && !b_adv;

  // read data is held in the store's output register, captured at the edge that takes the item
  assign pose = (b_meta.kind == KIND_READ) ? rdata : b_meta.shown;

  assign fmt.kind          = b_meta.kind;
  assign fmt.out_x         = pose.x;
  assign fmt.out_y         = pose.y;
  assign fmt.out_z         = pose.z;
  assign fmt.out_roll      = pose.roll;
  assign fmt.out_action    = pose.action;
  assign fmt.seq_state     = b_meta.seq_state;
  assign fmt.stored_count  = b_meta.stored_count;
  assign fmt.overflow_flag = b_meta.overflow_flag;
  assign fmt.generation    = b_meta.generation;
  assign fmt.event_res     = b_meta.event_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (b_adv) begin
        rsp_valid <= b_valid;
      end
      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_valid) begin
      rsp <= fmt;
    end
    if (accept) begin
      b_meta <= meta;
    end
  end

endmodule

`default_nettype wire

/* rtl/marked_sequence_loader_core.sv */
// An accepted item is registered in the wait stage, then in the output register.
// Throughput: one item per cycle while the output is not stalled; the store
//   has one write and one read port and each item uses at most one of them.
// Reset: synchronous, clears load state, counters and the timeout register
//   (to 30000) and holds off both inputs; the frame store is not cleared.
// ----------------------------------------------------------------------------
// marked_sequence_loader_core
// Marker-framed pose loader with frame store, tick timeout and readback.
// ----------------------------------------------------------------------------
`default_nettype none

module marked_sequence_loader_core
  import msl_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  wire         rsp_stall,
  output rsp_t        rsp,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data
);

  logic       accept;
  logic       busy;
  store_req_t acc;
  step_meta_t meta;
  pose_t      rdata;

  assign req_stall = busy || rst;
  assign accept    = req_valid && !req_stall;
  assign cfg_ready = !rst;

  msl_step u_step (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req      (req),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .acc      (acc),
    .meta     (meta)
  );

  msl_store u_store (
    .clk   (clk),
    .acc   (acc),
    .rdata (rdata)
  );

  msl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .meta      (meta),
    .rdata     (rdata),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

/* rtl/msl_checker.sv */
// ----------------------------------------------------------------------------
// msl_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "marked_sequence_loader_core_macros.svh"

module msl_checker
  import msl_pkg::*;
(
  input wire  clk,
  input wire  rst,
  input wire  rsp_valid,
  input wire  rsp_stall,
  input rsp_t rsp
);

  `MSL_ASSERT_NOW(a_reset_empty, $past(rst), !rsp_valid, "result valid right after reset")

  `MSL_ASSERT_NEXT(a_stall_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled item changed")

  `MSL_ASSERT_NOW(a_pose_state, rsp_valid && (rsp.kind == KIND_POSE), (rsp.seq_state == SEQ_IDLE) || (rsp.seq_state == SEQ_ERROR), "pose published while loading or ready")

  `MSL_ASSERT_NOW(a_bad_idx_zero, rsp_valid && (rsp.kind == KIND_BAD_IDX), (rsp.out_x == '0) && (rsp.out_y == '0) && (rsp.out_z == '0) && (rsp.out_roll == '0) && (rsp.out_action == '0), "invalid read carries data")

  `MSL_ASSERT_NOW(a_count_bound, rsp_valid, rsp.stored_count <= COUNT_W'(STORE_DEPTH), "stored count beyond store depth")

endmodule

bind marked_sequence_loader_core msl_checker u_msl_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

/* dv/marked_sequence_loader_checker.sv */
// ----------------------------------------------------------------------------
// marked_sequence_loader_checker
// Watches the item, result and register channels of the loader, keeps its
// own copy of the load state and frame store, and compares every result with
// the outcome worked out for the item that caused it.
// ----------------------------------------------------------------------------

module marked_sequence_loader_checker
  import msl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          outcomes_owed,
  output int          results_checked,
  output int          ready_loads,
  output int          overflow_hits,
  output int          timeout_hits,
  output int          data_reads
);

  logic [1:0]         load_phase;
  logic [COUNT_W-1:0] held;
  logic               spilled;
  logic [15:0]        gen;
  logic [15:0]        quiet;
  logic [15:0]        timeout_limit;
  pose_t              frames [STORE_DEPTH];
  rsp_t               loader_outcomes [$];

  function automatic logic is_marker(input req_t r, input logic [31:0] bits,
                                     input logic [15:0] roll_code,
                                     input logic [7:0] act_code);
    return r.pos_x == bits && r.pos_y == bits && r.pos_z == bits &&
           r.roll_tenths == roll_code && r.action_code == act_code;
  endfunction

  function automatic rsp_t with_pose(input rsp_t o, input pose_t p);
    rsp_t t;
    t = o;
    t.out_x      = p.x;
    t.out_y      = p.y;
    t.out_z      = p.z;
    t.out_roll   = p.roll;
    t.out_action = p.action;
    return t;
  endfunction

  function automatic string describe(input rsp_t r);
    return $sformatf({"kind %0d pose %h %h %h roll %0d act %h | ",
                      "state %0d count %0d ovf %0b gen %0d ev %0d"},
                     r.kind, r.out_x, r.out_y, r.out_z, r.out_roll, r.out_action,
                     r.seq_state, r.stored_count, r.overflow_flag, r.generation,
                     r.event_res);
  endfunction

  // one item through the loader: updates the local state, returns the result
  task automatic advance_loader(input req_t r, output rsp_t o);
    pose_t f;
    f.x      = r.pos_x;
    f.y      = r.pos_y;
    f.z      = r.pos_z;
    f.roll   = r.roll_tenths;
    f.action = r.action_code;
    o = '0;
    o.kind      = KIND_NONE;
    o.event_res = EV_NONE;
    case (r.command)
      CMD_FRAME: begin
        if (is_marker(r, BITS_FIVE, ROLL_BEGIN, ACT_BEGIN)) begin
          quiet      = '0;
          held       = '0;
          spilled    = 1'b0;
          load_phase = SEQ_LOADING;
          gen        = gen + 16'd1;
          o.event_res = EV_BEGAN;
        end else if (is_marker(r, BITS_EIGHT, ROLL_END, ACT_END)) begin
          quiet = '0;
          if (load_phase == SEQ_LOADING)
            load_phase = (held != 0 && !spilled) ? SEQ_READY : SEQ_IDLE;
          gen = gen + 16'd1;
          o.event_res = EV_FINISHED;
        end else if (load_phase == SEQ_LOADING) begin
          if (held >= STORE_DEPTH) begin
            spilled    = 1'b1;
            load_phase = SEQ_ERROR;
            gen        = gen + 16'd1;
            o.event_res = EV_OVERFLOW;
          end else begin
            frames[held[ADDR_W-1:0]] = f;
            held  = held + 1'b1;
            quiet = '0;
            o.event_res = EV_APPENDED;
          end
        end else if (load_phase == SEQ_IDLE || load_phase == SEQ_ERROR) begin
          o = with_pose(o, f);
          o.kind = KIND_POSE;
        end else begin
          o.event_res = EV_IGNORED;
        end
      end
      CMD_TICK: begin
        if (quiet != 16'hFFFF)
          quiet = quiet + 16'd1;
        if (load_phase == SEQ_LOADING && quiet >= timeout_limit) begin
          load_phase = SEQ_ERROR;
          gen        = gen + 16'd1;
          o.event_res = EV_TIMEOUT;
        end
      end
      CMD_READ: begin
        if (r.read_index < held) begin
          o = with_pose(o, frames[r.read_index]);
          o.kind = KIND_READ;
        end else begin
          o.kind = KIND_BAD_IDX;
        end
      end
      default: o.event_res = EV_IGNORED;
    endcase
    o.seq_state     = load_phase;
    o.stored_count  = held;
    o.overflow_flag = spilled;
    o.generation    = gen;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    rsp_t next_out;
    if (rst) begin
      load_phase    = SEQ_IDLE;
      held          = '0;
      spilled       = 1'b0;
      gen           = '0;
      quiet         = '0;
      timeout_limit = TIMEOUT_RESET;
      loader_outcomes.delete();
      fail_count      <= 0;
      outcomes_owed   <= 0;
      results_checked <= 0;
      ready_loads     <= 0;
      overflow_hits   <= 0;
      timeout_hits    <= 0;
      data_reads      <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        timeout_limit = cfg_data;

      if (rsp_valid && !rsp_stall) begin
        if (loader_outcomes.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected result: %s", describe(rsp));
        end else begin
          want = loader_outcomes.pop_front();
          results_checked <= results_checked + 1;
          if (rsp.kind !== want.kind || rsp.out_x !== want.out_x ||
              rsp.out_y !== want.out_y || rsp.out_z !== want.out_z ||
              rsp.out_roll !== want.out_roll || rsp.out_action !== want.out_action ||
              rsp.seq_state !== want.seq_state ||
              rsp.stored_count !== want.stored_count ||
              rsp.overflow_flag !== want.overflow_flag ||
              rsp.generation !== want.generation ||
              rsp.event_res !== want.event_res) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              $display("mismatch on result %0d", results_checked + 1);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(rsp));
            end
          end
          if (want.event_res == EV_FINISHED && want.seq_state == SEQ_READY)
            ready_loads <= ready_loads + 1;
          if (want.event_res == EV_OVERFLOW)
            overflow_hits <= overflow_hits + 1;
          if (want.event_res == EV_TIMEOUT)
            timeout_hits <= timeout_hits + 1;
          if (want.kind == KIND_READ)
            data_reads <= data_reads + 1;
        end
      end

      // a result never leaves in the cycle its item arrives
      if (req_valid && !req_stall) begin
        advance_loader(req, next_out);
        loader_outcomes.push_back(next_out);
      end
      outcomes_owed <= loader_outcomes.size();
    end
  end

endmodule

/* dv/marked_sequence_loader_core_tb.sv */
// ----------------------------------------------------------------------------
// marked_sequence_loader_core_tb
// Drives frames, ticks, reads and unused commands into the loader: a directed
// walk through the load states, then random load sequences and stray items
// under several timeout settings, with bursty input and a stalling output.
// ----------------------------------------------------------------------------

module marked_sequence_loader_core_tb;
  import msl_pkg::*;

  localparam logic [1:0] CMD_SPARE   = 2'd3;  // no function in the loader
  localparam int LIMIT_CYCLES        = 200000;
  localparam int LONG_HOLD           = 300;
  localparam int PHASES              = 7;
  localparam int ITEMS_PER_PHASE     = 232;

  typedef enum int {FLOW, LIGHT, HEAVY, TOGGLE} stall_mode_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        req_valid    = 1'b0;
  logic        req_stall;
  req_t        req          = '0;
  logic        rsp_valid;
  logic        rsp_stall    = 1'b0;
  rsp_t        rsp;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data     = '0;
  logic        hold_request = 1'b0;

  int fail_count, outcomes_owed, results_checked;
  int ready_loads, overflow_hits, timeout_hits, data_reads;
  int items_sent = 0;
  int burst_left = 0;
  int cycles     = 0;
  logic [15:0] timeout_now = TIMEOUT_RESET;

  marked_sequence_loader_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  marked_sequence_loader_checker chk (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req             (req),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .rsp             (rsp),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outcomes_owed   (outcomes_owed),
    .results_checked (results_checked),
    .ready_loads     (ready_loads),
    .overflow_hits   (overflow_hits),
    .timeout_hits    (timeout_hits),
    .data_reads      (data_reads)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outcomes_owed);
      $display("tb: failure");
      $finish;
    end
  end

  // random payload on every field, command fixed
  function automatic req_t payload(input logic [1:0] cmd);
    req_t r;
    r.command     = cmd;
    r.pos_x       = $urandom;
    r.pos_y       = $urandom;
    r.pos_z       = $urandom;
    r.roll_tenths = 16'($urandom_range(0, 65535));
    r.action_code = 8'($urandom_range(0, 255));
    r.read_index  = IDX_W'($urandom_range(0, 63));
    return r;
  endfunction

  function automatic req_t frame_req(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z, input logic [15:0] roll,
                                     input logic [7:0] act);
    req_t r;
    r = payload(CMD_FRAME);
    r.pos_x       = x;
    r.pos_y       = y;
    r.pos_z       = z;
    r.roll_tenths = roll;
    r.action_code = act;
    return r;
  endfunction

  function automatic req_t read_req(input int idx);
    req_t r;
    r = payload(CMD_READ);
    r.read_index = IDX_W'(idx);
    return r;
  endfunction

  // a marker with one bit flipped somewhere: must act as a plain frame
  function automatic req_t near_marker();
    req_t r;
    int   k;
    if ($urandom_range(0, 1))
      r = frame_req(BITS_FIVE, BITS_FIVE, BITS_FIVE, ROLL_BEGIN, ACT_BEGIN);
    else
      r = frame_req(BITS_EIGHT, BITS_EIGHT, BITS_EIGHT, ROLL_END, ACT_END);
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 4))
      0:       r.pos_x[k] = ~r.pos_x[k];
      1:       r.pos_y[k] = ~r.pos_y[k];
      2:       r.pos_z[k] = ~r.pos_z[k];
      3:       r.roll_tenths[k % 16] = ~r.roll_tenths[k % 16];
      default: r.action_code[k % 8] = ~r.action_code[k % 8];
    endcase
    return r;
  endfunction

  // offers one item and returns at the edge that takes it
  task automatic offer(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    if (r.command != CMD_SPARE)
      items_sent++;
  endtask

  task automatic send_marker(input logic [31:0] bits, input logic [15:0] roll,
                             input logic [7:0] act);
    offer(frame_req(bits, bits, bits, roll, act));
  endtask

  // drop valid and wait until every result has come back
  task automatic settle();
    req_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outcomes_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_stray();
    case ($urandom_range(0, 7))
      0, 1:    offer(payload(CMD_FRAME));
      2:       offer(payload(CMD_TICK));
      3:       offer(payload(CMD_READ));
      4:       offer(payload(CMD_SPARE));
      5:       offer(near_marker());
      6:       send_marker(BITS_EIGHT, ROLL_END, ACT_END);
      default: send_marker(BITS_FIVE, ROLL_BEGIN, ACT_BEGIN);
    endcase
  endtask

  // begin marker, stored frames with ticks and reads mixed in, usually an end
  task automatic run_load();
    int count, i, pick, len;
    pick = $urandom_range(0, 99);
    if (pick < 6)
      count = 0;
    else if (pick < 90)
      count = $urandom_range(1, 12);
    else if (pick < 95)
      count = STORE_DEPTH;
    else
      count = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
    send_marker(BITS_FIVE, ROLL_BEGIN, ACT_BEGIN);
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        len = (timeout_now <= 40) ? $urandom_range(1, timeout_now + 2)
                                  : $urandom_range(1, 3);
        repeat (len) offer(payload(CMD_TICK));
      end else if (pick < 24) begin
        offer(read_req($urandom_range(0, (i < 63) ? i + 1 : 63)));
      end
      offer(payload(CMD_FRAME));
    end
    if ($urandom_range(0, 9) != 0)
      send_marker(BITS_EIGHT, ROLL_END, ACT_END);
    repeat ($urandom_range(0, 4)) run_stray();
  endtask

  initial begin : receiver
    int          stretch, n;
    stall_mode_t mode;
    bit          held_once;
    held_once = 1'b0;
    forever begin
      stretch = $urandom_range(8, 120);
      mode    = stall_mode_t'($urandom_range(0, 3));
      for (n = 0; n < stretch; n++) begin
        @(posedge clk);
        if (hold_request && !held_once) begin
          // long back-pressure while items keep coming: fills the pipe
          held_once = 1'b1;
          rsp_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
          rsp_stall <= 1'b0;
        end else begin
          case (mode)
            FLOW:    rsp_stall <= 1'b0;
            LIGHT:   rsp_stall <= ($urandom_range(0, 3) == 0);
            HEAVY:   rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int          phase, quota;
    logic [15:0] next_limit;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk at the reset timeout
    offer(frame_req(32'h0, 32'h0, 32'h0, 16'h0000, 8'h00));
    offer(frame_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    offer(frame_req(32'h7F80_0000, 32'h8000_0000, BITS_FIVE, 16'h8000, ACT_BEGIN));
    offer(frame_req(BITS_EIGHT, 32'h0000_0001, 32'hFFFF_FFFE, 16'h7FFF, ACT_END));
    offer(read_req(0));
    offer(read_req(63));
    offer(payload(CMD_TICK));
    offer(payload(CMD_SPARE));
    send_marker(BITS_EIGHT, ROLL_END, ACT_END);         // end marker while idle
    offer(frame_req(BITS_FIVE, BITS_FIVE, BITS_FIVE, ROLL_BEGIN, ACT_END));
    send_marker(BITS_FIVE, ROLL_BEGIN, ACT_BEGIN);
    offer(payload(CMD_TICK));
    send_marker(BITS_EIGHT, ROLL_END, ACT_END);         // empty load back to idle
    send_marker(BITS_FIVE, ROLL_BEGIN, ACT_BEGIN);
    offer(frame_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 8'hFF));
    offer(frame_req(32'h0, 32'h0, 32'h0, 16'h7FFF, 8'h00));
    offer(read_req(0));
    offer(read_req(1));
    offer(read_req(2));
    send_marker(BITS_FIVE, ROLL_BEGIN, ACT_BEGIN);      // restart mid-load
    offer(payload(CMD_FRAME));
    send_marker(BITS_EIGHT, ROLL_END, ACT_END);         // to ready
    offer(payload(CMD_FRAME));
    offer(read_req(0));
    offer(payload(CMD_TICK));

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       next_limit = 16'd1;
        1:       next_limit = 16'd65535;
        2:       next_limit = 16'd3;
        3:       next_limit = 16'd20;
        4:       next_limit = 16'd2;
        5:       next_limit = 16'd40;
        default: next_limit = 16'd7;
      endcase
      settle();
      cfg_data  <= next_limit;
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid   <= 1'b0;
      timeout_now = next_limit;
      if (phase == 3)
        hold_request <= 1'b1;
      quota = items_sent + ITEMS_PER_PHASE;
      while (items_sent < quota) begin
        if ($urandom_range(0, 9) < 7)
          run_load();
        else
          repeat ($urandom_range(1, 6)) run_stray();
      end
    end
    settle();

    $display("%0d items over %0d timeout settings, %0d results checked",
             items_sent, PHASES + 1, results_checked);
    $display("loads ending ready %0d, overflows %0d, timeouts %0d, frames read back %0d",
             ready_loads, overflow_hits, timeout_hits, data_reads);
    if (fail_count == 0 && outcomes_owed == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/msl_pkg.sv
rtl/msl_store.sv
rtl/msl_step.sv
rtl/msl_outq.sv
rtl/marked_sequence_loader_core.sv
rtl/msl_checker.sv
dv/marked_sequence_loader_checker.sv
dv/marked_sequence_loader_core_tb.sv
